[rtl/core/pcbt_pkg.sv]
// Shared types and constants for the pulse-code burst transmitter.
package pcbt_pkg;

   // Longest code that a burst may send; larger lengths saturate here.
   localparam int unsigned MAX_SYMBOLS = 32;

   localparam int unsigned CODE_W    = 64;
   localparam int unsigned LEN_W     = 6;
   localparam int unsigned WAIT_W    = 24;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned SYM_IDX_W = $clog2(CODE_W / 2);

   localparam logic [WAIT_W-1:0]  SHORT_WAIT_RST  = WAIT_W'(10000);
   localparam logic [WAIT_W-1:0]  LONG_WAIT_RST   = WAIT_W'(120000);
   localparam logic [COUNT_W-1:0] BURST_COUNT_RST = COUNT_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ON_CODE     = 3'd0,
      REG_OFF_CODE    = 3'd1,
      REG_ON_LENGTH   = 3'd2,
      REG_OFF_LENGTH  = 3'd3,
      REG_SHORT_WAIT  = 3'd4,
      REG_LONG_WAIT   = 3'd5,
      REG_BURST_COUNT = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      SYM_A = 2'd0,
      SYM_B = 2'd1,
      SYM_C = 2'd2,
      SYM_D = 2'd3
   } symbol_type;

   typedef enum logic {
      KIND_TICK      = 1'b0,
      KIND_SET_STATE = 1'b1
   } kind_type;

   // Decoded view of the symbol at the current position.
   typedef struct packed {
      logic active;       // position lies inside the code
      logic first_half;   // line level during the first half
      logic second_half;  // line level during the second half
   } sym_type;

endpackage

[rtl/core/pcbt_sym_dec.sv]
// Symbol selection and half-symbol level decode for the current burst position.
module pcbt_sym_dec
   import pcbt_pkg::*;
(
   input  logic [CODE_W-1:0] code,
   input  logic [LEN_W-1:0]  length,
   input  logic [LEN_W-1:0]  position,
   output sym_type           sym
);

   logic [LEN_W-1:0] len_sat;
   symbol_type       code_sym;

   // Clamp the length to the symbol capacity of a code word.
   assign len_sat  = (length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : length;
   assign code_sym = symbol_type'(code[{position[SYM_IDX_W-1:0], 1'b0} +: 2]);

   always_comb begin
      sym.active      = (position < len_sat) && (position < LEN_W'(CODE_W / 2));
      sym.first_half  = 1'b0;
      sym.second_half = 1'b0;
      case (code_sym)
         SYM_A: begin
            sym.first_half = 1'b1;
         end
         SYM_B: begin
            sym.second_half = 1'b1;
         end
         SYM_C: begin
            sym.first_half  = 1'b1;
            sym.second_half = 1'b1;
         end
         SYM_D: begin
            sym.first_half  = 1'b0;
         end
         default: begin
            sym.first_half  = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/pulse_code_burst_transmitter_top.sv]
// Top level of the pulse-code burst transmitter: state update, result register, CSRs.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_kind, req_want_on
//   rsp     | out       | rsp_valid/rsp_stall | rsp_line_level, rsp_sending,
//           |           |                     | rsp_sending_on_code
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// One item per cycle while req_stall is low; its result is visible in the cycle after the transfer.
// The whole state update is a single combinational pass into the state registers,
// which also hold the result fields.
// Reset (synchronous) loads the register defaults and starts an off-code burst.
// rsp_stall, while a result is valid, holds the result and stalls req in the same cycle.
module pulse_code_burst_transmitter_top
   import pcbt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic                 req_want_on,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_line_level,
   output logic                 rsp_sending,
   output logic                 rsp_sending_on_code,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]    csr_wdata
);

   logic [CODE_W-1:0]  on_code_ff, off_code_ff;
   logic [LEN_W-1:0]   on_length_ff, off_length_ff;
   logic [WAIT_W-1:0]  short_wait_ff, long_wait_ff;
   logic [COUNT_W-1:0] burst_count_ff;

   logic               in_burst_ff, in_burst_in;
   logic [LEN_W-1:0]   symbol_position_ff, symbol_position_in;
   logic               half_position_ff, half_position_in;
   logic [COUNT_W-1:0] sent_in_group_ff, sent_in_group_in;
   logic [WAIT_W-1:0]  wait_left_ff, wait_left_in;
   logic               requested_on_ff, requested_on_in;
   logic               latched_on_ff, latched_on_in;
   logic               change_pending_ff, change_pending_in;
   logic               line_out_ff, line_out_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic [COUNT_W:0]   sent_next;
   sym_type            sym;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------- CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         on_code_ff     <= '0;
         off_code_ff    <= '0;
         on_length_ff   <= '0;
         off_length_ff  <= '0;
         short_wait_ff  <= SHORT_WAIT_RST;
         long_wait_ff   <= LONG_WAIT_RST;
         burst_count_ff <= BURST_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_ON_CODE:     on_code_ff     <= csr_wdata;
            REG_OFF_CODE:    off_code_ff    <= csr_wdata;
            REG_ON_LENGTH:   on_length_ff   <= csr_wdata[LEN_W-1:0];
            REG_OFF_LENGTH:  off_length_ff  <= csr_wdata[LEN_W-1:0];
            REG_SHORT_WAIT:  short_wait_ff  <= csr_wdata[WAIT_W-1:0];
            REG_LONG_WAIT:   long_wait_ff   <= csr_wdata[WAIT_W-1:0];
            REG_BURST_COUNT: burst_count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pcbt_sym_dec u_sym_dec (
      .code     (latched_on_ff ? on_code_ff : off_code_ff),
      .length   (latched_on_ff ? on_length_ff : off_length_ff),
      .position (symbol_position_ff),
      .sym      (sym)
   );

   assign sent_next = {1'b0, sent_in_group_ff} + (COUNT_W+1)'(1);

   // --------------------------------------------------------- state update
   always_comb begin
      in_burst_in        = in_burst_ff;
      symbol_position_in = symbol_position_ff;
      half_position_in   = half_position_ff;
      sent_in_group_in   = sent_in_group_ff;
      wait_left_in       = wait_left_ff;
      requested_on_in    = requested_on_ff;
      latched_on_in      = latched_on_ff;
      change_pending_in  = change_pending_ff;
      line_out_in        = line_out_ff;

      if (kind_type'(req_kind) == KIND_SET_STATE) begin
         requested_on_in = req_want_on;
         if (in_burst_ff) begin
            change_pending_in = 1'b1;
         end else begin
            sent_in_group_in   = '0;
            in_burst_in        = 1'b1;
            latched_on_in      = req_want_on;
            symbol_position_in = '0;
            half_position_in   = 1'b0;
            wait_left_in       = '0;
            change_pending_in  = 1'b0;
         end
      end else if (in_burst_ff) begin
         if (sym.active) begin
            line_out_in = half_position_ff ? sym.second_half : sym.first_half;
            if (half_position_ff) begin
               half_position_in   = 1'b0;
               symbol_position_in = symbol_position_ff + LEN_W'(1);
            end else begin
               half_position_in = 1'b1;
            end
         end else begin
            // End of burst: drive low, then restart, long wait or short wait.
            line_out_in        = 1'b0;
            in_burst_in        = 1'b0;
            symbol_position_in = '0;
            half_position_in   = 1'b0;
            if (change_pending_ff) begin
               sent_in_group_in  = '0;
               in_burst_in       = 1'b1;
               latched_on_in     = requested_on_ff;
               wait_left_in      = '0;
               change_pending_in = 1'b0;
            end else if (sent_next >= {1'b0, burst_count_ff}) begin
               sent_in_group_in = '0;
               wait_left_in     = long_wait_ff;
            end else begin
               sent_in_group_in = sent_next[COUNT_W-1:0];
               wait_left_in     = short_wait_ff;
            end
         end
      end else if (wait_left_ff <= WAIT_W'(1)) begin
         in_burst_in        = 1'b1;
         latched_on_in      = requested_on_ff;
         symbol_position_in = '0;
         half_position_in   = 1'b0;
         wait_left_in       = '0;
         change_pending_in  = 1'b0;
      end else begin
         wait_left_in = wait_left_ff - WAIT_W'(1);
      end
   end

   // Result stays valid until taken; a new transfer refills it at once.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_burst_ff        <= 1'b1;
         symbol_position_ff <= '0;
         half_position_ff   <= 1'b0;
         sent_in_group_ff   <= '0;
         wait_left_ff       <= '0;
         requested_on_ff    <= 1'b0;
         latched_on_ff      <= 1'b0;
         change_pending_ff  <= 1'b0;
         line_out_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_burst_ff        <= in_burst_in;
            symbol_position_ff <= symbol_position_in;
            half_position_ff   <= half_position_in;
            sent_in_group_ff   <= sent_in_group_in;
            wait_left_ff       <= wait_left_in;
            requested_on_ff    <= requested_on_in;
            latched_on_ff      <= latched_on_in;
            change_pending_ff  <= change_pending_in;
            line_out_ff        <= line_out_in;
         end
      end
   end

   // State only moves on a transfer, so it doubles as the result payload.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_line_level      = line_out_ff;
   assign rsp_sending         = in_burst_ff;
   assign rsp_sending_on_code = latched_on_ff;

   // ----------------------------------------------------------- assertions
   a_pending_only_in_burst: assert property (@(posedge clock) disable iff (reset)
      change_pending_ff |-> in_burst_ff)
      else $error("change pending outside a burst");

   a_no_wait_in_burst: assert property (@(posedge clock) disable iff (reset)
      in_burst_ff |-> (wait_left_ff == '0))
      else $error("wait counter live during a burst");

   a_idle_line_low: assert property (@(posedge clock) disable iff (reset)
      !in_burst_ff |-> (!line_out_ff && symbol_position_ff == '0 && !half_position_ff))
      else $error("line or position not cleared while waiting");

   a_result_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("transfer without a result");

   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(in_burst_ff) && $stable(wait_left_ff) && $stable(line_out_ff))
      else $error("state moved without a transfer");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the pulse-code burst transmitter top level.
module testbench;
   import pcbt_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 112;
   localparam int SCRIPT_ROWS = 25;

   typedef struct packed {
      logic line;
      logic sending;
      logic on_code;
   } level_type;

   // Transmitter state as the predictor tracks it.
   typedef struct packed {
      logic              in_burst;
      logic [LEN_W-1:0]  sym_pos;
      logic              half;
      logic [COUNT_W-1:0] group_sent;
      logic [WAIT_W-1:0] wait_left;
      logic              want;
      logic              latched;
      logic              pending;
      logic              line;
   } xmit_type;

   typedef struct {
      logic [CODE_W-1:0]  on_code;
      logic [CODE_W-1:0]  off_code;
      logic [LEN_W-1:0]   on_len;
      logic [LEN_W-1:0]   off_len;
      logic [WAIT_W-1:0]  short_wait;
      logic [WAIT_W-1:0]  long_wait;
      logic [COUNT_W-1:0] burst_count;
   } code_cfg_type;

   typedef struct packed {
      logic              is_reg;
      csr_index_type     idx;
      logic [CODE_W-1:0] value;
      kind_type          kind;
      logic              want;
      logic              typed;
      level_type         result;
   } step_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_kind;
   logic                 req_want_on;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_line_level;
   logic                 rsp_sending;
   logic                 rsp_sending_on_code;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CODE_W-1:0]    csr_wdata;

   xmit_type     st;
   code_cfg_type cfg;
   level_type    due_levels [$];
   int           fail_count   = 0;
   logic         burst_gaps   = 1'b0;
   logic         hold_off_req = 1'b0;

   // Directed rows; a set typed bit means the expected result is given in the row.
   step_row_type script [SCRIPT_ROWS] = '{
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b1, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b1, 1'b1, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_SET_STATE, 1'b1, 1'b1, 3'b011},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b1, 3'b001},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_SET_STATE, 1'b0, 1'b1, 3'b010},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b1, 3'b000},
      '{1'b1, REG_ON_CODE,     64'hE4, KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b1, REG_ON_LENGTH,   64'd4,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b1, REG_SHORT_WAIT,  64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b1, REG_LONG_WAIT,   64'd1,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b1, REG_BURST_COUNT, 64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_SET_STATE, 1'b1, 1'b1, 3'b011},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b1, 3'b111},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b1, 3'b011},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b1, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_SET_STATE, 1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b0, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b1, 3'b000},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b0, 1'b1, 3'b010},
      '{1'b0, REG_ON_CODE,     64'd0,  KIND_TICK,      1'b1, 1'b1, 3'b000}
   };

   pulse_code_burst_transmitter_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_want_on         (req_want_on),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_line_level      (rsp_line_level),
      .rsp_sending         (rsp_sending),
      .rsp_sending_on_code (rsp_sending_on_code),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void begin_burst();
      st.in_burst  = 1'b1;
      st.latched   = st.want;
      st.sym_pos   = '0;
      st.half      = 1'b0;
      st.wait_left = '0;
      st.pending   = 1'b0;
   endfunction

   // One tick inside a burst: emit the next half symbol or close the burst.
   function automatic void burst_step();
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
      symbol_type        sym;
      len  = st.latched ? cfg.on_len : cfg.off_len;
      code = st.latched ? cfg.on_code : cfg.off_code;
      if (len > MAX_SYMBOLS) len = LEN_W'(MAX_SYMBOLS);
      if (st.sym_pos < len) begin
         sym = symbol_type'(code[2 * int'(st.sym_pos) +: 2]);
         if (st.half) begin
            st.line    = (sym == SYM_B || sym == SYM_C);
            st.half    = 1'b0;
            st.sym_pos = st.sym_pos + LEN_W'(1);
         end else begin
            st.line = (sym == SYM_A || sym == SYM_C);
            st.half = 1'b1;
         end
      end else begin
         st.line     = 1'b0;
         st.in_burst = 1'b0;
         st.sym_pos  = '0;
         st.half     = 1'b0;
         if (st.pending) begin
            st.group_sent = '0;
            begin_burst();
         end else if (int'(st.group_sent) + 1 >= int'(cfg.burst_count)) begin
            st.group_sent = '0;
            st.wait_left  = cfg.long_wait;
         end else begin
            st.group_sent = st.group_sent + COUNT_W'(1);
            st.wait_left  = cfg.short_wait;
         end
      end
   endfunction

   function automatic level_type next_level(kind_type kind, logic want);
      level_type r;
      if (kind == KIND_SET_STATE) begin
         st.want = want;
         if (st.in_burst) begin
            st.pending = 1'b1;
         end else begin
            st.group_sent = '0;
            begin_burst();
         end
      end else if (st.in_burst) begin
         burst_step();
      end else if (st.wait_left <= WAIT_W'(1)) begin
         begin_burst();
      end else begin
         st.wait_left = st.wait_left - WAIT_W'(1);
      end
      r.line    = st.line;
      r.sending = st.in_burst;
      r.on_code = st.latched;
      return r;
   endfunction

   task automatic flag(string what, logic [2:0] wanted, logic [2:0] got);
      fail_count++;
      $display("%0t %s: expected %b, got %b", $time, what, wanted, got);
   endtask

   // Leaves csr_we high; the caller drops it after the last write.
   task automatic write_reg(csr_index_type idx, logic [CODE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_ON_CODE:     cfg.on_code     = value;
         REG_OFF_CODE:    cfg.off_code    = value;
         REG_ON_LENGTH:   cfg.on_len      = value[LEN_W-1:0];
         REG_OFF_LENGTH:  cfg.off_len     = value[LEN_W-1:0];
         REG_SHORT_WAIT:  cfg.short_wait  = value[WAIT_W-1:0];
         REG_LONG_WAIT:   cfg.long_wait   = value[WAIT_W-1:0];
         REG_BURST_COUNT: cfg.burst_count = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_item(kind_type kind, logic want, logic typed, level_type given);
      int        gap;
      level_type predicted;
      gap = burst_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_want_on <= want;
      do @(posedge clock); while (req_stall);
      predicted = next_level(kind, want);
      due_levels.push_back(typed ? given : predicted);
   endtask

   // Hold the sender until every result is back, then let the block go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (due_levels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin : stimulus
      logic              wrote_reg;
      logic [CODE_W-1:0] on_c, off_c;
      logic [LEN_W-1:0]  on_l, off_l;
      logic [WAIT_W-1:0] sw, lw;
      logic [COUNT_W-1:0] bc;
      kind_type          kind;
      wrote_reg   = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_kind    <= 1'b0;
      req_want_on <= 1'b0;
      csr_we      <= 1'b0;
      csr_index   <= REG_ON_CODE;
      csr_wdata   <= '0;
      st          = '0;
      st.in_burst = 1'b1;
      cfg.on_code     = '0;
      cfg.off_code    = '0;
      cfg.on_len      = '0;
      cfg.off_len     = '0;
      cfg.short_wait  = SHORT_WAIT_RST;
      cfg.long_wait   = LONG_WAIT_RST;
      cfg.burst_count = BURST_COUNT_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_reg) begin
            if (!wrote_reg) settle();
            write_reg(script[i].idx, script[i].value);
            wrote_reg = 1'b1;
         end else begin
            if (wrote_reg) csr_we <= 1'b0;
            wrote_reg = 1'b0;
            send_item(script[i].kind, script[i].want, script[i].typed, script[i].result);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         on_c  = {$urandom, $urandom};
         off_c = {$urandom, $urandom};
         on_l  = LEN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 8));
         off_l = LEN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 8));
         sw    = WAIT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 60)
                                                     : $urandom_range(0, 6));
         lw    = WAIT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 90)
                                                     : $urandom_range(0, 12));
         bc    = COUNT_W'($urandom_range(0, 15));
         case (phase)
            0: begin
               on_c = '1; on_l = 6'd63; off_l = 6'd32; sw = '0; lw = '0; bc = 4'd15;
            end
            1: begin
               on_c = '0; off_c = '1; on_l = '0; off_l = '0; sw = '1; lw = '1; bc = 4'd1;
            end
            2: begin
               on_l = 6'd32; off_l = 6'd1; sw = 24'd1; lw = 24'd1; bc = '0;
            end
            default: ;
         endcase
         write_reg(REG_ON_CODE, on_c);
         write_reg(REG_OFF_CODE, off_c);
         write_reg(REG_ON_LENGTH, CODE_W'(on_l));
         write_reg(REG_OFF_LENGTH, CODE_W'(off_l));
         write_reg(REG_SHORT_WAIT, CODE_W'(sw));
         write_reg(REG_LONG_WAIT, CODE_W'(lw));
         write_reg(REG_BURST_COUNT, CODE_W'(bc));
         csr_we <= 1'b0;
         // back-to-back offers while the receiver holds off fill the block up
         burst_gaps = (phase == 3) || ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 40) hold_off_req = 1'b1;
            if (phase == 5 && n == 50) settle();
            kind = ($urandom_range(0, 9) == 0) ? KIND_SET_STATE : KIND_TICK;
            send_item(kind, 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin : rsp_side
      int         stall_left, quiet_left, hold_left;
      logic       was_stalled;
      logic [2:0] last_out;
      level_type  exp_level;
      stall_left  = 0;
      quiet_left  = 0;
      hold_left   = 0;
      was_stalled = 1'b0;
      last_out    = '0;
      rsp_stall   <= 1'b0;
      forever begin
         @(posedge clock);
         // a stalled result must hold until its transfer
         if (was_stalled &&
             (rsp_valid !== 1'b1 ||
              {rsp_line_level, rsp_sending, rsp_sending_on_code} !== last_out))
            flag("held result", last_out, {rsp_line_level, rsp_sending, rsp_sending_on_code});
         was_stalled = !reset && rsp_valid && rsp_stall;
         last_out    = {rsp_line_level, rsp_sending, rsp_sending_on_code};
         if (!reset && rsp_valid && !rsp_stall) begin
            if (due_levels.size() == 0) begin
               flag("unexpected result", 3'bxxx, last_out);
            end else begin
               exp_level = due_levels.pop_front();
               if (rsp_line_level !== exp_level.line)
                  flag("line_level", 3'(exp_level.line), 3'(rsp_line_level));
               if (rsp_sending !== exp_level.sending)
                  flag("sending", 3'(exp_level.sending), 3'(rsp_sending));
               if (rsp_sending_on_code !== exp_level.on_code)
                  flag("sending_on_code", 3'(exp_level.on_code), 3'(rsp_sending_on_code));
            end
            if (quiet_left > 0) quiet_left--;
            else if ($urandom_range(0, 7) == 0) quiet_left = 40;
            stall_left = (quiet_left > 0) ? 0 : $urandom_range(0, 15);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_stall   <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("testbench: errors");
      $finish;
   end

endmodule

[sim.f]
rtl/core/pcbt_pkg.sv
rtl/core/pcbt_sym_dec.sv
rtl/core/pulse_code_burst_transmitter_top.sv
dv/testbench.sv
